/* src/b2d_pkg.sv */
package b2d_pkg;

    localparam int IDX_W   = 25;   // linear index
    localparam int CIN_W   = 12;   // input coordinate
    localparam int CRD_W   = 13;   // output coordinate
    localparam int DIM_W   = 13;   // width / height register
    localparam int SIDE_W  = 9;    // block side register
    localparam int AREA_W  = 17;   // side * side
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam int MAX_DIM_DEF   = 4096;
    localparam int MAX_BLOCK_DEF = 256;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_SIDE   = 2'd2
    } reg_idx_t;

    localparam logic OP_TO_INDEX = 1'b0;
    localparam logic OP_TO_COORD = 1'b1;

    // context riding along the first divider chain and the multiply stages
    typedef struct packed {
        logic             op;
        logic [IDX_W-1:0] index;
        logic             in_bounds;
    } ctx_front_t;

    // context riding along the index / area chain
    typedef struct packed {
        logic             op;
        logic             in_range;
        logic [IDX_W-1:0] index_out;
        logic             in_bounds;
        logic [DIM_W-1:0] blocks_down;
    } ctx_mid_t;

    // context riding along the final chain
    typedef struct packed {
        logic             op;
        logic             in_range;
        logic [IDX_W-1:0] index_out;
        logic             in_bounds;
    } ctx_back_t;

endpackage

/* src/b2d_div_cell.sv */
module b2d_div_cell #(
    parameter int NW = 13,
    parameter int DW = 9
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [DW-1:0] rem_in,
    input  logic [NW-1:0] acc_in,
    input  logic [DW-1:0] den_in,
    output logic [DW-1:0] rem_out,
    output logic [NW-1:0] acc_out,
    output logic [DW-1:0] den_out
);

    logic [DW-1:0] rem_reg, rem_next;
    logic [NW-1:0] acc_reg, acc_next;
    logic [DW-1:0] den_reg;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    // one restoring step: bring down the top dividend bit, subtract if it fits
    always_comb begin
        trial    = {rem_in, acc_in[NW-1]};
        diff     = trial - {1'b0, den_in};
        ge       = (trial >= {1'b0, den_in});
        rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
        acc_next = {acc_in[NW-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= rem_next;
            acc_reg <= acc_next;
            den_reg <= den_in;
        end
    end

    assign rem_out = rem_reg;
    assign acc_out = acc_reg;
    assign den_out = den_reg;

endmodule

/* src/b2d_div_chain.sv */
module b2d_div_chain #(
    parameter int NW    = 13,
    parameter int DW    = 9,
    parameter int LANES = 1,
    parameter int SBW   = 1
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [LANES-1:0][NW-1:0]   in_num,
    input  logic [LANES-1:0][DW-1:0]   in_den,
    input  logic [SBW-1:0]             in_sb,
    output logic                       out_valid,
    output logic [LANES-1:0][NW-1:0]   out_quo,
    output logic [LANES-1:0][DW-1:0]   out_rem,
    output logic [SBW-1:0]             out_sb
);

    logic [LANES-1:0][DW-1:0] rem_w [NW+1];
    logic [LANES-1:0][NW-1:0] acc_w [NW+1];
    logic [LANES-1:0][DW-1:0] den_w [NW+1];
    logic [NW-1:0]            valid_reg;
    logic [SBW-1:0]           sb_reg [NW];

    assign rem_w[0] = '0;
    assign acc_w[0] = in_num;
    assign den_w[0] = in_den;

    for (genvar g = 0; g < NW; g++) begin : g_step
        for (genvar l = 0; l < LANES; l++) begin : g_lane
            b2d_div_cell #(.NW(NW), .DW(DW)) u_cell (
                .aclk    (aclk),
                .en      (en),
                .rem_in  (rem_w[g][l]),
                .acc_in  (acc_w[g][l]),
                .den_in  (den_w[g][l]),
                .rem_out (rem_w[g+1][l]),
                .acc_out (acc_w[g+1][l]),
                .den_out (den_w[g+1][l])
            );
        end

        if (g == 0) begin : g_first
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[g] <= 1'b0;
                end else if (en) begin
                    valid_reg[g] <= in_valid;
                end
            end
            always_ff @(posedge aclk) begin
                if (en) begin
                    sb_reg[g] <= in_sb;
                end
            end
        end else begin : g_rest
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[g] <= 1'b0;
                end else if (en) begin
                    valid_reg[g] <= valid_reg[g-1];
                end
            end
            always_ff @(posedge aclk) begin
                if (en) begin
                    sb_reg[g] <= sb_reg[g-1];
                end
            end
        end
    end

    assign out_valid = valid_reg[NW-1];
    assign out_quo   = acc_w[NW];
    assign out_rem   = rem_w[NW];
    assign out_sb    = sb_reg[NW-1];

endmodule

/* src/blocked_2d_address_map_unit.sv */
// Tiled column-major address translator.
// Requests enter on the s_ stream: s_tuser selects the operation (0 maps a
// column/row pair to a linear index, 1 maps a linear index back to a
// column/row pair). Each request yields exactly one result on the m_ stream,
// in order; m_tuser carries the in-bounds / cell-in-use flag.
// Geometry (width, height, block side) is set over the APB port at
// 0x0, 0x4, 0x8 and must only change while no request is in flight.
// From accept to result the pipe runs through three chains of
// restoring divide cells (13, 25 and 25 cells, one quotient bit per cell)
// plus three multiply/add stages, one coordinate stage and the output
// register. A new request is taken every cycle while m_tready is high.
// The whole pipe advances as one; when the receiver stalls with a result
// held in the output register, s_tready drops and every stage holds.
// Reset (synchronous, aresetn low) empties the pipe and sets width,
// height and block side to 1.
module blocked_2d_address_map_unit #(
    parameter int MAX_DIM   = b2d_pkg::MAX_DIM_DEF,
    parameter int MAX_BLOCK = b2d_pkg::MAX_BLOCK_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // APB configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [b2d_pkg::ADDR_W-1:0]  paddr,
    input  logic [b2d_pkg::DATA_W-1:0]  pwdata,
    output logic [b2d_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    // requests
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [55:0]                 s_tdata,  // column_in[11:0], row_in[23:12],
                                                  // index_in[48:24], zero pad
    input  logic                        s_tuser,  // operation
    // results
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [55:0]                 m_tdata,  // index_out[24:0], column_out[37:25],
                                                  // row_out[50:38], zero pad
    output logic                        m_tuser   // cell_valid
);

    import b2d_pkg::*;

    // ---------------- configuration registers ----------------
    logic [DIM_W-1:0]  width_reg, height_reg;
    logic [SIDE_W-1:0] side_reg;
    reg_idx_t          wr_idx;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_idx = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= DIM_W'(1);
            height_reg <= DIM_W'(1);
            side_reg   <= SIDE_W'(1);
        end else if (wr_en) begin
            unique case (wr_idx)
                REG_WIDTH:  width_reg  <= pwdata[DIM_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[DIM_W-1:0];
                REG_SIDE:   side_reg   <= pwdata[SIDE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (wr_idx)
            REG_WIDTH:  prdata = DATA_W'(width_reg);
            REG_HEIGHT: prdata = DATA_W'(height_reg);
            REG_SIDE:   prdata = DATA_W'(side_reg);
            default:    prdata = '0;
        endcase
    end

    // effective geometry: dims clamp to MAX_DIM, side 0 acts as 1, side clamps to MAX_BLOCK
    logic [DIM_W-1:0]  w_eff, h_eff;
    logic [SIDE_W-1:0] s_eff;

    always_comb begin
        w_eff = (32'(width_reg)  > MAX_DIM) ? DIM_W'(MAX_DIM) : width_reg;
        h_eff = (32'(height_reg) > MAX_DIM) ? DIM_W'(MAX_DIM) : height_reg;
        priority if (side_reg == '0) begin
            s_eff = SIDE_W'(1);
        end else if (32'(side_reg) > MAX_BLOCK) begin
            s_eff = SIDE_W'(MAX_BLOCK);
        end else begin
            s_eff = side_reg;
        end
    end

    // ---------------- pipe control ----------------
    logic adv;
    logic m_valid_reg;

    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;

    // ---------------- front: request decode ----------------
    logic [CIN_W-1:0] col_in, row_in;
    logic [IDX_W-1:0] idx_in;
    ctx_front_t       ctx_f_in;

    assign col_in = s_tdata[11:0];
    assign row_in = s_tdata[23:12];
    assign idx_in = s_tdata[48:24];

    always_comb begin
        ctx_f_in.op        = s_tuser;
        ctx_f_in.index     = idx_in;
        ctx_f_in.in_bounds = ({1'b0, col_in} < w_eff) && ({1'b0, row_in} < h_eff);
    end

    // chain 1: blocks down, blocks across, column / side, row / side
    logic [3:0][DIM_W-1:0]  c1_num;
    logic [3:0][SIDE_W-1:0] c1_den;
    logic [3:0][DIM_W-1:0]  c1_quo;
    logic [3:0][SIDE_W-1:0] c1_rem;
    logic                   c1_valid;
    logic [$bits(ctx_front_t)-1:0] c1_sb;
    ctx_front_t             c1_ctx;

    assign c1_num[0] = h_eff + DIM_W'(s_eff) - DIM_W'(1);
    assign c1_num[1] = w_eff + DIM_W'(s_eff) - DIM_W'(1);
    assign c1_num[2] = DIM_W'(col_in);
    assign c1_num[3] = DIM_W'(row_in);
    assign c1_den    = {4{s_eff}};

    b2d_div_chain #(
        .NW(DIM_W), .DW(SIDE_W), .LANES(4), .SBW($bits(ctx_front_t))
    ) u_chain_geom (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (s_tvalid),
        .in_num    (c1_num),
        .in_den    (c1_den),
        .in_sb     (ctx_f_in),
        .out_valid (c1_valid),
        .out_quo   (c1_quo),
        .out_rem   (c1_rem),
        .out_sb    (c1_sb)
    );

    assign c1_ctx = c1_sb;

    // ---------------- multiply stage 1 ----------------
    logic             m1_valid_reg;
    ctx_front_t       m1_ctx_reg;
    logic [AREA_W-1:0] m1_area_reg;
    logic [IDX_W-1:0] m1_t1_reg, m1_pab_reg;
    logic [AREA_W-1:0] m1_sc_reg;
    logic [DIM_W-1:0] m1_rq_reg, m1_bd_reg;
    logic [SIDE_W-1:0] m1_rr_reg;
    logic [2*DIM_W-1:0] t1_full, pab_full;
    logic [2*SIDE_W-1:0] area_full, sc_full;

    assign t1_full   = c1_quo[0] * c1_quo[2];
    assign pab_full  = c1_quo[1] * c1_quo[0];
    assign area_full = s_eff * s_eff;
    assign sc_full   = s_eff * c1_rem[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_valid_reg <= 1'b0;
        end else if (adv) begin
            m1_valid_reg <= c1_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m1_ctx_reg  <= c1_ctx;
            m1_area_reg <= area_full[AREA_W-1:0];
            m1_t1_reg   <= t1_full[IDX_W-1:0];
            m1_pab_reg  <= pab_full[IDX_W-1:0];
            m1_sc_reg   <= sc_full[AREA_W-1:0];
            m1_rq_reg   <= c1_quo[3];
            m1_rr_reg   <= c1_rem[3];
            m1_bd_reg   <= c1_quo[0];
        end
    end

    // ---------------- multiply stage 2 ----------------
    logic              m2_valid_reg;
    ctx_front_t        m2_ctx_reg;
    logic [AREA_W-1:0] m2_area_reg, m2_off_reg;
    logic [IDX_W-1:0]  m2_bb_reg;
    logic [IDX_W:0]    m2_pad_reg;
    logic [DIM_W-1:0]  m2_bd_reg;
    logic [IDX_W+AREA_W-1:0] pad_full;

    assign pad_full = m1_pab_reg * m1_area_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m2_valid_reg <= 1'b0;
        end else if (adv) begin
            m2_valid_reg <= m1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m2_ctx_reg  <= m1_ctx_reg;
            m2_area_reg <= m1_area_reg;
            m2_bb_reg   <= m1_t1_reg + IDX_W'(m1_rq_reg);
            m2_pad_reg  <= pad_full[IDX_W:0];
            m2_off_reg  <= m1_sc_reg + AREA_W'(m1_rr_reg);
            m2_bd_reg   <= m1_bd_reg;
        end
    end

    // ---------------- multiply stage 3: index, range check ----------------
    logic              m3_valid_reg;
    ctx_front_t        m3_ctx_reg;
    logic [AREA_W-1:0] m3_area_reg;
    logic [IDX_W-1:0]  m3_idx_reg;
    logic              m3_inr_reg;
    logic [DIM_W-1:0]  m3_bd_reg;
    logic [IDX_W+AREA_W-1:0] base_full;

    assign base_full = m2_area_reg * m2_bb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m3_valid_reg <= 1'b0;
        end else if (adv) begin
            m3_valid_reg <= m2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m3_ctx_reg  <= m2_ctx_reg;
            m3_area_reg <= m2_area_reg;
            m3_idx_reg  <= base_full[IDX_W-1:0] + IDX_W'(m2_off_reg);
            m3_inr_reg  <= {1'b0, m2_ctx_reg.index} < m2_pad_reg;
            m3_bd_reg   <= m2_bd_reg;
        end
    end

    // chain 2: index / area -> block number, cell within block
    ctx_mid_t                     c2_ctx_in, c2_ctx;
    logic [0:0][IDX_W-1:0]        c2_num, c2_quo;
    logic [0:0][AREA_W-1:0]       c2_den, c2_rem;
    logic                         c2_valid;
    logic [$bits(ctx_mid_t)-1:0]  c2_sb;

    always_comb begin
        c2_ctx_in.op          = m3_ctx_reg.op;
        c2_ctx_in.in_range    = m3_inr_reg;
        c2_ctx_in.index_out   = m3_idx_reg;
        c2_ctx_in.in_bounds   = m3_ctx_reg.in_bounds;
        c2_ctx_in.blocks_down = m3_bd_reg;
    end

    assign c2_num[0] = m3_ctx_reg.index;
    assign c2_den[0] = m3_area_reg;

    b2d_div_chain #(
        .NW(IDX_W), .DW(AREA_W), .LANES(1), .SBW($bits(ctx_mid_t))
    ) u_chain_block (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (m3_valid_reg),
        .in_num    (c2_num),
        .in_den    (c2_den),
        .in_sb     (c2_ctx_in),
        .out_valid (c2_valid),
        .out_quo   (c2_quo),
        .out_rem   (c2_rem),
        .out_sb    (c2_sb)
    );

    assign c2_ctx = c2_sb;

    // chain 3: block / blocks_down and cell / side
    ctx_back_t                    c3_ctx_in, c3_ctx;
    logic [1:0][IDX_W-1:0]        c3_num, c3_quo;
    logic [1:0][DIM_W-1:0]        c3_den, c3_rem;
    logic                         c3_valid;
    logic [$bits(ctx_back_t)-1:0] c3_sb;

    always_comb begin
        c3_ctx_in.op        = c2_ctx.op;
        c3_ctx_in.in_range  = c2_ctx.in_range;
        c3_ctx_in.index_out = c2_ctx.index_out;
        c3_ctx_in.in_bounds = c2_ctx.in_bounds;
    end

    assign c3_num[0] = c2_quo[0];
    assign c3_den[0] = c2_ctx.blocks_down;
    assign c3_num[1] = IDX_W'(c2_rem[0]);
    assign c3_den[1] = DIM_W'(s_eff);

    b2d_div_chain #(
        .NW(IDX_W), .DW(DIM_W), .LANES(2), .SBW($bits(ctx_back_t))
    ) u_chain_cell (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (c2_valid),
        .in_num    (c3_num),
        .in_den    (c3_den),
        .in_sb     (c3_ctx_in),
        .out_valid (c3_valid),
        .out_quo   (c3_quo),
        .out_rem   (c3_rem),
        .out_sb    (c3_sb)
    );

    assign c3_ctx = c3_sb;

    // ---------------- coordinate stage ----------------
    logic             f1_valid_reg;
    ctx_back_t        f1_ctx_reg;
    logic [CRD_W-1:0] f1_col_reg, f1_row_reg;
    logic [IDX_W+SIDE_W-1:0] colb_full;
    logic [DIM_W+SIDE_W-1:0] rowb_full;

    assign colb_full = c3_quo[0] * s_eff;
    assign rowb_full = c3_rem[0] * s_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg <= 1'b0;
        end else if (adv) begin
            f1_valid_reg <= c3_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            f1_ctx_reg <= c3_ctx;
            f1_col_reg <= colb_full[CRD_W-1:0] + c3_quo[1][CRD_W-1:0];
            f1_row_reg <= rowb_full[CRD_W-1:0] + c3_rem[1][CRD_W-1:0];
        end
    end

    // ---------------- output register ----------------
    logic [IDX_W-1:0] out_idx_reg, out_idx_next;
    logic [CRD_W-1:0] out_col_reg, out_col_next;
    logic [CRD_W-1:0] out_row_reg, out_row_next;
    logic             out_ok_reg, out_ok_next;

    always_comb begin
        out_idx_next = '0;
        out_col_next = '0;
        out_row_next = '0;
        out_ok_next  = 1'b0;
        if (f1_ctx_reg.op == OP_TO_INDEX) begin
            if (f1_ctx_reg.in_bounds) begin
                out_idx_next = f1_ctx_reg.index_out;
                out_ok_next  = 1'b1;
            end
        end else begin
            if (f1_ctx_reg.in_range) begin
                out_col_next = f1_col_reg;
                out_row_next = f1_row_reg;
                out_ok_next  = (f1_col_reg < w_eff) && (f1_row_reg < h_eff);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= f1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_idx_reg <= out_idx_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            out_ok_reg  <= out_ok_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, out_row_reg, out_col_reg, out_idx_reg};
    assign m_tuser  = out_ok_reg;

endmodule

/* dv/tb_blocked_2d_address_map_unit.sv */
module tb_blocked_2d_address_map_unit;
    import b2d_pkg::*;

    // Pipe depth from accept to result; allow margin when draining.
    localparam int PIPE_LAT = 68;

    typedef struct packed {
        logic [IDX_W-1:0] index_out;
        logic [CRD_W-1:0] column_out;
        logic [CRD_W-1:0] row_out;
        logic             cell_valid;
    } xlat_result_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [55:0]         s_tdata = '0;  // column_in[11:0], row_in[23:12], index_in[48:24]
    logic                s_tuser = 1'b0; // operation
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [55:0]         m_tdata;       // index_out[24:0], column_out[37:25], row_out[50:38]
    logic                m_tuser;       // cell_valid

    // Shadow geometry registers, raw as written.
    logic [DIM_W-1:0]  geo_width = 1;
    logic [DIM_W-1:0]  geo_height = 1;
    logic [SIDE_W-1:0] geo_side = 1;

    xlat_result_t expected_q[$];
    int  mismatch_count = 0;
    bit  rx_hold = 1'b0;    // forces receiver stall for a long stretch
    int  rx_stall_pct = 30; // receiver stall probability in percent

    blocked_2d_address_map_unit u_top (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    initial begin
        #4000000;
        $display("Simulation FAILED");
        $finish;
    end

    // Translation predictor: computes the result of one request.
    function automatic xlat_result_t predict_xlat(logic op, logic [CIN_W-1:0] col,
                                                  logic [CIN_W-1:0] row,
                                                  logic [IDX_W-1:0] idx);
        longint unsigned w, h, s, area, bdown, bacross, padded, blk, cell_ofs, c, r;
        xlat_result_t res;
        w = (geo_width > MAX_DIM_DEF) ? MAX_DIM_DEF : geo_width;
        h = (geo_height > MAX_DIM_DEF) ? MAX_DIM_DEF : geo_height;
        s = geo_side;
        if (s == 0) s = 1;
        if (s > MAX_BLOCK_DEF) s = MAX_BLOCK_DEF;
        area = s * s;
        bdown = (h + s - 1) / s;
        bacross = (w + s - 1) / s;
        res = '0;
        if (op == OP_TO_INDEX) begin
            if (col < w && row < h) begin
                res.index_out = IDX_W'(area * (bdown * (col / s) + (row / s))
                                       + s * (col % s) + (row % s));
                res.cell_valid = 1'b1;
            end
        end else begin
            padded = bacross * bdown * area;
            if (idx < padded) begin
                blk = idx / area;
                cell_ofs = idx % area;
                c = (blk / bdown) * s + cell_ofs / s;
                r = (blk % bdown) * s + cell_ofs % s;
                res.column_out = CRD_W'(c);
                res.row_out = CRD_W'(r);
                res.cell_valid = (c < w && r < h);
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    // Receiver: random stalls, plus a long hold when requested.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Result checker.
    always @(posedge aclk) begin
        xlat_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result", m_tdata[24:0], 0);
            end else begin
                want = expected_q.pop_front();
                if (m_tdata[24:0] !== want.index_out)
                    report_mismatch("index_out", m_tdata[24:0], want.index_out);
                if (m_tdata[37:25] !== want.column_out)
                    report_mismatch("column_out", m_tdata[37:25], want.column_out);
                if (m_tdata[50:38] !== want.row_out)
                    report_mismatch("row_out", m_tdata[50:38], want.row_out);
                if (m_tuser !== want.cell_valid)
                    report_mismatch("cell_valid", m_tuser, want.cell_valid);
            end
        end
    end

    // APB write: setup then access; pready is always high.
    task automatic write_geometry(reg_idx_t which, logic [DATA_W-1:0] value);
        @(posedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= ADDR_W'(4 * int'(which)); pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (which)
            REG_WIDTH:  geo_width  = value[DIM_W-1:0];
            REG_HEIGHT: geo_height = value[DIM_W-1:0];
            default:    geo_side   = value[SIDE_W-1:0];
        endcase
    endtask

    // Stop offering, wait for every pending result, then let the pipe settle.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (PIPE_LAT + 10) @(posedge aclk);
    endtask

    task automatic set_geometry(int w, int h, int s);
        drain_results();
        write_geometry(REG_WIDTH, w);
        write_geometry(REG_HEIGHT, h);
        write_geometry(REG_SIDE, s);
    endtask

    // Send one request; the prediction is queued on acceptance.
    task automatic send_request(logic op, logic [CIN_W-1:0] col, logic [CIN_W-1:0] row,
                                logic [IDX_W-1:0] idx);
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {7'd0, idx, row, col};
        do @(posedge aclk); while (!s_tready);
        expected_q.push_back(predict_xlat(op, col, row, idx));
    endtask

    task automatic idle_sender(int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    // Random request biased toward the live region of the current geometry.
    task automatic send_random_request();
        int w, h, s, span;
        logic [CIN_W-1:0] col, row;
        logic [IDX_W-1:0] idx;
        w = (geo_width == 0) ? 1 : ((geo_width > 4096) ? 4096 : geo_width);
        h = (geo_height == 0) ? 1 : ((geo_height > 4096) ? 4096 : geo_height);
        s = (geo_side == 0) ? 1 : ((geo_side > 256) ? 256 : geo_side);
        span = ((w + s - 1) / s) * ((h + s - 1) / s) * s * s;
        if ($urandom_range(9) < 8) begin
            col = CIN_W'($urandom_range(w + 2 < 4096 ? w + 2 : 4095));
            row = CIN_W'($urandom_range(h + 2 < 4096 ? h + 2 : 4095));
            idx = IDX_W'($urandom_range(span + 4 < 25'h1FFFFFF ? span + 4 : 25'h1FFFFFF));
        end else begin
            col = CIN_W'($urandom); row = CIN_W'($urandom); idx = IDX_W'($urandom);
        end
        send_request(1'($urandom_range(1)), col, row, idx);
    endtask

    task automatic test_reset_geometry();
        send_request(OP_TO_INDEX, 0, 0, 0);
        send_request(OP_TO_INDEX, 1, 0, 0);
        send_request(OP_TO_COORD, 0, 0, 0);
        send_request(OP_TO_COORD, 0, 0, 1);
        idle_sender(1);
    endtask

    task automatic test_directed_extremes();
        // largest geometry
        set_geometry(4096, 4096, 256);
        send_request(OP_TO_INDEX, 4095, 4095, 0);
        send_request(OP_TO_INDEX, 0, 0, 25'h1FFFFFF);
        send_request(OP_TO_COORD, 12'hFFF, 12'hFFF, 16777215);
        send_request(OP_TO_COORD, 0, 0, 16777216);
        send_request(OP_TO_COORD, 0, 0, 25'h1FFFFFF);
        // oversized registers clamp, zero side acts as one
        set_geometry(8191, 8191, 0);
        send_request(OP_TO_INDEX, 4095, 4095, 0);
        send_request(OP_TO_COORD, 0, 0, 16777215);
        set_geometry(4100, 300, 511);
        send_request(OP_TO_INDEX, 4095, 299, 0);
        send_request(OP_TO_COORD, 0, 0, 18931199);
        send_request(OP_TO_COORD, 0, 0, 18931200);
        // zero width / height: nothing valid
        set_geometry(0, 5, 3);
        send_request(OP_TO_INDEX, 0, 0, 0);
        send_request(OP_TO_COORD, 0, 0, 0);
        set_geometry(5, 0, 3);
        send_request(OP_TO_INDEX, 0, 0, 0);
        send_request(OP_TO_COORD, 0, 0, 0);
        // padding cells and out-of-bounds coordinates
        set_geometry(5, 7, 4);
        send_request(OP_TO_INDEX, 4, 6, 0);
        send_request(OP_TO_INDEX, 5, 0, 0);
        send_request(OP_TO_INDEX, 0, 7, 0);
        send_request(OP_TO_COORD, 0, 0, 31);
        send_request(OP_TO_COORD, 0, 0, 63);
        send_request(OP_TO_COORD, 0, 0, 64);
        idle_sender(1);
    endtask

    task automatic test_random_geometries();
        int w, h, s;
        for (int phase = 0; phase < 16; phase++) begin
            case (phase % 4)
                0: begin w = $urandom_range(1, 40); h = $urandom_range(1, 40);
                         s = $urandom_range(0, 9); end
                1: begin w = $urandom_range(1, 8191); h = $urandom_range(1, 8191);
                         s = $urandom_range(0, 511); end
                2: begin w = $urandom_range(1, 300); h = $urandom_range(1, 300);
                         s = $urandom_range(1, 64); end
                default: begin w = $urandom_range(0, 4096); h = $urandom_range(0, 4096);
                         s = $urandom_range(250, 260); end
            endcase
            rx_stall_pct = (phase % 3 == 0) ? 0 : $urandom_range(10, 60);
            set_geometry(w, h, s);
            for (int n = 0; n < 50; ) begin
                int burst;
                burst = $urandom_range(1, 12);
                for (int b = 0; b < burst && n < 50; b++, n++) send_random_request();
                if ($urandom_range(3) != 0) idle_sender($urandom_range(1, 5));
            end
            idle_sender(1);
        end
    endtask

    // Receiver holds off long enough to fill the pipe and stall the input.
    task automatic test_backpressure();
        set_geometry(37, 53, 6);
        fork
            begin
                rx_hold = 1'b1;
                repeat (300) @(posedge aclk);
                rx_hold = 1'b0;
            end
            for (int n = 0; n < 100; n++) send_random_request();
        join
        idle_sender(1);
        drain_results();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_geometry();
        test_directed_extremes();
        test_backpressure();
        test_random_geometries();
        drain_results();
        if (mismatch_count == 0 && expected_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

/* filelist.f */
src/b2d_pkg.sv
src/b2d_div_cell.sv
src/b2d_div_chain.sv
src/blocked_2d_address_map_unit.sv
dv/tb_blocked_2d_address_map_unit.sv
